>>> rtl/spg_pkg.sv
package spg_pkg;

    localparam int OP_W        = 2;
    localparam int ANGLE_W     = 8;
    localparam int US_W        = 12;
    localparam int CFG_INDEX_W = 1;
    localparam int HIGH_W      = 16;
    localparam int LOW_W       = 19;
    localparam int PROD_W      = 20;
    localparam int WIDTH_US_W  = 13;

    localparam logic [ANGLE_W-1:0] FULL_ANGLE = 8'd180;
    localparam logic [PROD_W-1:0]  FULL_ANGLE_P = 20'd180;

    // floor(2^30 / 180); estimate is exact or one low
    localparam int                RECIP_SHIFT = 30;
    localparam int                RECIP_W     = 23;
    localparam logic [RECIP_W-1:0] RECIP_180  = 23'd5965232;

    // two frame gaps added to the low phase
    localparam logic [LOW_W-1:0]  GAP_CYCLES = 19'd272384;
    localparam logic [HIGH_W-1:0] HIGH_MAX   = 16'hFFFF;

    localparam logic [US_W-1:0] MIN_PULSE_RESET = 12'd550;
    localparam logic [US_W-1:0] MAX_PULSE_RESET = 12'd2450;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_PULSE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PULSE = 1'd1;

    localparam int PIPE_STAGES = 6;
    localparam int QUEUE_DEPTH = 16;
    localparam int QUEUE_AW    = 4;
    localparam int CREDIT_W    = 5;

    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 2'd0,
        OP_SET_ANGLE = 2'd1,
        OP_STOP      = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } phase_t;

    typedef struct packed {
        op_t                op;
        logic [HIGH_W-1:0]  high_cycles;
        logic [LOW_W-1:0]   low_cycles;
    } qword_t;

    typedef struct packed {
        logic   push;
        qword_t word;
    } qpush_t;

endpackage

>>> rtl/spg_scale.sv
module spg_scale #(
    parameter int CLOCK_MHZ      = 16,
    parameter int TIMER_PRESCALE = 256
) (
    input  logic                        clk,
    input  logic [spg_pkg::ANGLE_W-1:0] angle,
    input  logic [spg_pkg::US_W-1:0]    min_pulse_us,
    input  logic [spg_pkg::US_W-1:0]    max_pulse_us,
    output logic [spg_pkg::HIGH_W-1:0]  cycles
);
    import spg_pkg::*;

    localparam int MHZ_W    = $clog2(CLOCK_MHZ + 1);
    localparam int SCALED_W = WIDTH_US_W + MHZ_W;
    localparam int RP_SHIFT = SCALED_W;
    localparam int RP_W     = RP_SHIFT + 1;
    localparam longint RP_INT = (longint'(1) << RP_SHIFT) / TIMER_PRESCALE;
    localparam logic [RP_W-1:0]     RP       = RP_W'(RP_INT);
    localparam logic [MHZ_W-1:0]    MHZ      = MHZ_W'(CLOCK_MHZ);
    localparam logic [SCALED_W-1:0] PRESCALE = SCALED_W'(TIMER_PRESCALE);
    localparam int E_W   = PROD_W + RECIP_W;
    localparam int M_W   = SCALED_W + RP_W;
    localparam int CMP_W = (SCALED_W > HIGH_W) ? SCALED_W : HIGH_W;

    logic [US_W-1:0]       span;
    logic [PROD_W-1:0]     prod_reg;
    logic [PROD_W-1:0]     prod2_reg;
    logic [US_W-1:0]       est_reg;
    logic [E_W-1:0]        est_full;
    logic [PROD_W-1:0]     rem;
    logic [US_W-1:0]       quot;
    logic [WIDTH_US_W-1:0] width_reg;
    logic [SCALED_W-1:0]   scaled_reg;
    logic [SCALED_W-1:0]   scaled2_reg;
    logic [SCALED_W-1:0]   est2_reg;
    logic [M_W-1:0]        est2_full;
    logic [SCALED_W-1:0]   rem2;
    logic [SCALED_W-1:0]   floor_cyc;
    logic [HIGH_W-1:0]     cycles_reg;

    assign span     = (max_pulse_us > min_pulse_us) ? (max_pulse_us - min_pulse_us) : '0;
    assign est_full = E_W'(prod_reg) * E_W'(RECIP_180);
    assign rem      = prod2_reg - PROD_W'(est_reg) * FULL_ANGLE_P;
    assign quot     = est_reg + US_W'(rem >= FULL_ANGLE_P);
    assign est2_full = M_W'(scaled_reg) * M_W'(RP);
    assign rem2     = scaled2_reg - est2_reg * PRESCALE;
    assign floor_cyc = (rem2 >= PRESCALE) ? (scaled2_reg - rem2 + PRESCALE)
                                          : (scaled2_reg - rem2);

    always_ff @(posedge clk)
    begin
        prod_reg    <= PROD_W'(span) * PROD_W'(angle);
        prod2_reg   <= prod_reg;
        est_reg     <= US_W'(est_full >> RECIP_SHIFT);
        width_reg   <= WIDTH_US_W'(min_pulse_us) + WIDTH_US_W'(quot);
        scaled_reg  <= SCALED_W'(width_reg) * SCALED_W'(MHZ);
        scaled2_reg <= scaled_reg;
        est2_reg    <= SCALED_W'(est2_full >> RP_SHIFT);
        cycles_reg  <= (CMP_W'(floor_cyc) > CMP_W'(HIGH_MAX)) ? HIGH_MAX
                                                              : HIGH_W'(floor_cyc);
    end

    assign cycles = cycles_reg;

endmodule

>>> rtl/spg_front.sv
module spg_front #(
    parameter int CLOCK_MHZ      = 16,
    parameter int TIMER_PRESCALE = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [spg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [spg_pkg::US_W-1:0]        cfg_data,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  logic [spg_pkg::OP_W-1:0]        operation,
    input  logic [spg_pkg::ANGLE_W-1:0]     angle,
    input  logic                            pop,
    output spg_pkg::qpush_t                 qpush
);
    import spg_pkg::*;

    logic [US_W-1:0]        min_pulse_reg;
    logic [US_W-1:0]        max_pulse_reg;
    logic [CREDIT_W-1:0]    credit_reg;
    logic [CREDIT_W-1:0]    credit_next;
    logic                   accept;
    op_t                    op_dec;
    logic [ANGLE_W-1:0]     angle_sat;
    logic                   valid0_reg;
    op_t                    op0_reg;
    logic [ANGLE_W-1:0]     angle0_reg;
    logic [ANGLE_W-1:0]     mirror0_reg;
    logic [PIPE_STAGES-1:0] valid_pipe_reg;
    op_t                    op_pipe_reg [PIPE_STAGES];
    logic [HIGH_W-1:0]      high_cyc;
    logic [HIGH_W-1:0]      mirror_cyc;

    assign cmd_ready = (credit_reg != '0);
    assign accept    = cmd_valid && cmd_ready;
    assign angle_sat = (angle > FULL_ANGLE) ? FULL_ANGLE : angle;

    always_comb
    begin
        case (operation)
            OP_SET_ANGLE: op_dec = OP_SET_ANGLE;
            OP_STOP:      op_dec = OP_STOP;
            default:      op_dec = OP_TICK;
        endcase
    end

    always_comb
    begin
        credit_next = credit_reg + CREDIT_W'(pop) - CREDIT_W'(accept);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pulse_reg <= MIN_PULSE_RESET;
            max_pulse_reg <= MAX_PULSE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_PULSE: min_pulse_reg <= cfg_data;
                CFG_MAX_PULSE: max_pulse_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg     <= CREDIT_W'(QUEUE_DEPTH);
            valid0_reg     <= 1'b0;
            valid_pipe_reg <= '0;
        end
        else
        begin
            credit_reg     <= credit_next;
            valid0_reg     <= accept;
            valid_pipe_reg <= {valid_pipe_reg[PIPE_STAGES-2:0], valid0_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        op0_reg        <= op_dec;
        angle0_reg     <= angle_sat;
        mirror0_reg    <= FULL_ANGLE - angle_sat;
        op_pipe_reg[0] <= op0_reg;
        for (int i = 1; i < PIPE_STAGES; i++)
        begin
            op_pipe_reg[i] <= op_pipe_reg[i-1];
        end
    end

    spg_scale #(
        .CLOCK_MHZ      (CLOCK_MHZ),
        .TIMER_PRESCALE (TIMER_PRESCALE)
    ) u_scale_high (
        .clk          (clk),
        .angle        (angle0_reg),
        .min_pulse_us (min_pulse_reg),
        .max_pulse_us (max_pulse_reg),
        .cycles       (high_cyc)
    );

    spg_scale #(
        .CLOCK_MHZ      (CLOCK_MHZ),
        .TIMER_PRESCALE (TIMER_PRESCALE)
    ) u_scale_low (
        .clk          (clk),
        .angle        (mirror0_reg),
        .min_pulse_us (min_pulse_reg),
        .max_pulse_us (max_pulse_reg),
        .cycles       (mirror_cyc)
    );

    always_comb
    begin
        qpush.push             = valid_pipe_reg[PIPE_STAGES-1];
        qpush.word.op          = op_pipe_reg[PIPE_STAGES-1];
        qpush.word.high_cycles = high_cyc;
        qpush.word.low_cycles  = LOW_W'(mirror_cyc) + GAP_CYCLES;
    end

endmodule

>>> rtl/spg_queue.sv
module spg_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  spg_pkg::qpush_t  qpush,
    input  logic             pop,
    output logic             q_valid,
    output spg_pkg::qword_t  q_word
);
    import spg_pkg::*;

    qword_t              mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [CREDIT_W-1:0] count_reg;
    logic [CREDIT_W-1:0] count_next;

    assign q_valid = (count_reg != '0);
    assign q_word  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + CREDIT_W'(qpush.push) - CREDIT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (qpush.push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (qpush.push)
        begin
            mem[wr_ptr_reg] <= qpush.word;
        end
    end

endmodule

>>> rtl/spg_back.sv
module spg_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  spg_pkg::qword_t q_word,
    output logic            pop,
    output logic            pulse_valid,
    input  logic            pulse_ready,
    output logic            pin_level,
    output logic            frame_start,
    output logic            running
);
    import spg_pkg::*;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [LOW_W-1:0]   counter_reg;
    logic [LOW_W-1:0]   counter_next;
    logic [HIGH_W-1:0]  high_reg;
    logic [HIGH_W-1:0]  high_next;
    logic [LOW_W-1:0]   low_reg;
    logic [LOW_W-1:0]   low_next;
    logic               out_valid_reg;
    logic               pin_reg;
    logic               fstart_reg;
    logic               run_reg;
    logic               pin_next;
    logic               fstart_next;
    logic               run_next;
    logic               high_done;
    logic               low_done;

    assign pop       = q_valid && (!out_valid_reg || pulse_ready);
    assign high_done = (counter_reg >= LOW_W'(high_reg));
    assign low_done  = (counter_reg >= low_reg);

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        counter_next = counter_reg;
        high_next    = high_reg;
        low_next     = low_reg;
        case (q_word.op)
            OP_SET_ANGLE:
            begin
                high_next    = q_word.high_cycles;
                low_next     = q_word.low_cycles;
                phase_next   = (q_word.high_cycles == '0) ? PH_LOW : PH_HIGH;
                counter_next = LOW_W'(1);
            end
            OP_STOP:
            begin
                phase_next   = PH_IDLE;
                counter_next = '0;
            end
            default:
            begin
                case (phase_reg)
                    PH_HIGH:
                    begin
                        if (high_done)
                        begin
                            phase_next   = PH_LOW;
                            counter_next = LOW_W'(1);
                        end
                        else
                        begin
                            counter_next = counter_reg + 1'b1;
                        end
                    end
                    PH_LOW:
                    begin
                        if (low_done)
                        begin
                            phase_next   = (high_reg == '0) ? PH_LOW : PH_HIGH;
                            counter_next = LOW_W'(1);
                        end
                        else
                        begin
                            counter_next = counter_reg + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        endcase
    end

    // outputs
    always_comb
    begin
        pin_next    = (phase_next == PH_HIGH);
        run_next    = (phase_next != PH_IDLE);
        case (q_word.op)
            OP_SET_ANGLE: fstart_next = 1'b1;
            OP_STOP:      fstart_next = 1'b0;
            default:      fstart_next = (phase_reg == PH_LOW) && low_done;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            counter_reg   <= '0;
            high_reg      <= '0;
            low_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg   <= phase_next;
                counter_reg <= counter_next;
                high_reg    <= high_next;
                low_reg     <= low_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pulse_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pin_reg    <= pin_next;
            fstart_reg <= fstart_next;
            run_reg    <= run_next;
        end
    end

    assign pulse_valid = out_valid_reg;
    assign pin_level   = pin_reg;
    assign frame_start = fstart_reg;
    assign running     = run_reg;

endmodule

>>> rtl/servo_pulse_generator_top.sv
// Servo pulse generator. Each accepted command word is one step of the pulse
// timebase (tick), a set-angle that restarts the frame, or a stop that drives
// the pin low; every word yields exactly one result word carrying pin level,
// frame start and running. One word per clock is sustained while pulse_ready
// stays high. Each word passes one input register, six stages of the two
// pulse-width scaling pipelines (high and mirrored low phase), then the
// 16-entry queue feeding the phase sequencer and its output register. The 16
// credits of that queue bound how many words may be in flight, so a stalled
// result side throttles cmd_ready after 16 words. Width registers are to
// be written while idle (not enforced) and apply at the next set-angle command.
module servo_pulse_generator_top #(
    parameter int CLOCK_MHZ      = 16,
    parameter int TIMER_PRESCALE = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [spg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [spg_pkg::US_W-1:0]        cfg_data,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  logic [spg_pkg::OP_W-1:0]        operation,
    input  logic [spg_pkg::ANGLE_W-1:0]     angle,
    output logic                            pulse_valid,
    input  logic                            pulse_ready,
    output logic                            pin_level,
    output logic                            frame_start,
    output logic                            running
);
    import spg_pkg::*;

    qpush_t qpush;
    qword_t q_word;
    logic   q_valid;
    logic   pop;

    spg_front #(
        .CLOCK_MHZ      (CLOCK_MHZ),
        .TIMER_PRESCALE (TIMER_PRESCALE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .operation (operation),
        .angle     (angle),
        .pop       (pop),
        .qpush     (qpush)
    );

    spg_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .qpush   (qpush),
        .pop     (pop),
        .q_valid (q_valid),
        .q_word  (q_word)
    );

    spg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_word      (q_word),
        .pop         (pop),
        .pulse_valid (pulse_valid),
        .pulse_ready (pulse_ready),
        .pin_level   (pin_level),
        .frame_start (frame_start),
        .running     (running)
    );

endmodule

>>> rtl/spg_checker.sv
module spg_checker (
    input logic clk,
    input logic rst_n,
    input logic pulse_valid,
    input logic pulse_ready,
    input logic pin_level,
    input logic frame_start,
    input logic running
);

    // stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pulse_valid && !pulse_ready |=> pulse_valid
            && $stable(pin_level) && $stable(frame_start) && $stable(running))
        else $error("result word changed while stalled");

    a_pin_running: assert property (@(posedge clk) disable iff (!rst_n)
        pulse_valid && pin_level |-> running)
        else $error("pin high while train stopped");

    a_frame_running: assert property (@(posedge clk) disable iff (!rst_n)
        pulse_valid && frame_start |-> running)
        else $error("frame start while train stopped");

endmodule

bind servo_pulse_generator_top spg_checker u_spg_checker (.*);

>>> bench/tb.sv
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLOCK_MHZ      = 16;
    localparam int          TIMER_PRESCALE = 256;
    localparam int unsigned ANGLE_LIMIT    = 180;
    localparam int unsigned FRAME_GAP      = 2 * 133 * 1024;
    localparam int unsigned HIGH_CAP       = 16'hFFFF;
    localparam int          LONG_HOLD      = 400;
    localparam int          SUB_WORDS      = 30;

    localparam logic [spg_pkg::OP_W-1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [spg_pkg::OP_W-1:0]    op;
        logic [spg_pkg::ANGLE_W-1:0] ang;
    } cmd_word_t;

    typedef struct packed {
        logic pin;
        logic fstart;
        logic run;
    } pulse_word_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [spg_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [spg_pkg::US_W-1:0]        cfg_data = '0;
    logic                            cmd_valid = 1'b0;
    logic                            cmd_ready;
    logic [spg_pkg::OP_W-1:0]        operation = '0;
    logic [spg_pkg::ANGLE_W-1:0]     angle = '0;
    logic                            pulse_valid;
    logic                            pulse_ready = 1'b0;
    logic                            pin_level;
    logic                            frame_start;
    logic                            running;

    servo_pulse_generator_top #(
        .CLOCK_MHZ      (CLOCK_MHZ),
        .TIMER_PRESCALE (TIMER_PRESCALE)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .operation   (operation),
        .angle       (angle),
        .pulse_valid (pulse_valid),
        .pulse_ready (pulse_ready),
        .pin_level   (pin_level),
        .frame_start (frame_start),
        .running     (running)
    );

    always #5 clk = ~clk;

    // pulse train state as the block should hold it
    spg_pkg::phase_t             train_phase = spg_pkg::PH_IDLE;
    logic [spg_pkg::LOW_W-1:0]   phase_count = '0;
    logic [spg_pkg::HIGH_W-1:0]  high_len = '0;
    logic [spg_pkg::LOW_W-1:0]   low_len = '0;
    logic [spg_pkg::US_W-1:0]    min_us = spg_pkg::MIN_PULSE_RESET;
    logic [spg_pkg::US_W-1:0]    max_us = spg_pkg::MAX_PULSE_RESET;

    cmd_word_t   cmd_queue[$];
    pulse_word_t pulse_expect[$];
    cmd_word_t   next_word;

    int  send_idle_pct = 31;
    int  recv_idle_pct = 62;
    int  fail_count = 0;
    int  result_count = 0;
    int  queued_words = 0;
    int  hold_trigger = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    logic cmd_taken = 1'b0;

    function automatic int unsigned pulse_cycles(input int unsigned ang);
        int unsigned span;
        int unsigned width_us;
        int unsigned cyc;
        span = (max_us > min_us) ? (max_us - min_us) : 0;
        width_us = min_us + (span * ang) / ANGLE_LIMIT;
        cyc = ((width_us * CLOCK_MHZ) / TIMER_PRESCALE) * TIMER_PRESCALE;
        return (cyc > HIGH_CAP) ? HIGH_CAP : cyc;
    endfunction

    function automatic void open_frame();
        train_phase = (high_len == 0) ? spg_pkg::PH_LOW : spg_pkg::PH_HIGH;
        phase_count = 19'd1;
    endfunction

    function automatic pulse_word_t step_train(input cmd_word_t w);
        pulse_word_t res;
        int unsigned a;
        logic        fs;
        fs = 1'b0;
        if (w.op == spg_pkg::OP_SET_ANGLE)
        begin
            a = (int'(w.ang) > ANGLE_LIMIT) ? ANGLE_LIMIT : int'(w.ang);
            high_len = 16'(pulse_cycles(a));
            low_len = 19'(pulse_cycles(ANGLE_LIMIT - a) + FRAME_GAP);
            open_frame();
            fs = 1'b1;
        end
        else if (w.op == spg_pkg::OP_STOP)
        begin
            train_phase = spg_pkg::PH_IDLE;
            phase_count = '0;
        end
        else if (train_phase == spg_pkg::PH_HIGH)
        begin
            if (phase_count >= 19'(high_len))
            begin
                train_phase = spg_pkg::PH_LOW;
                phase_count = 19'd1;
            end
            else
                phase_count = phase_count + 1'b1;
        end
        else if (train_phase == spg_pkg::PH_LOW)
        begin
            if (phase_count >= low_len)
            begin
                open_frame();
                fs = 1'b1;
            end
            else
                phase_count = phase_count + 1'b1;
        end
        res.pin = (train_phase == spg_pkg::PH_HIGH);
        res.fstart = fs;
        res.run = (train_phase != spg_pkg::PH_IDLE);
        return res;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic check_word(input pulse_word_t got);
        pulse_word_t want;
        if (pulse_expect.size() == 0)
        begin
            note_failure($sformatf("unexpected word: pin %0b start %0b run %0b",
                got.pin, got.fstart, got.run));
            return;
        end
        want = pulse_expect.pop_front();
        if (got != want)
            note_failure($sformatf(
                "word %0d: expected pin %0b start %0b run %0b, got pin %0b start %0b run %0b",
                result_count, want.pin, want.fstart, want.run, got.pin, got.fstart, got.run));
        result_count++;
    endtask

    // monitor: check results, then predict for the word accepted at this edge
    always @(posedge clk)
    begin
        cmd_taken <= rst_n && cmd_valid && cmd_ready;
        if (rst_n && pulse_valid && pulse_ready)
            check_word('{pin_level, frame_start, running});
        if (rst_n && cmd_valid && cmd_ready)
            pulse_expect.push_back(step_train('{operation, angle}));
    end

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
            cmd_valid <= 1'b0;
        else if (!cmd_valid || cmd_taken)
        begin
            if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_word = cmd_queue.pop_front();
                cmd_valid <= 1'b1;
                operation <= next_word.op;
                angle <= next_word.ang;
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // receiver, with an occasional long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pulse_ready <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            pulse_ready <= 1'b0;
        end
        else if (hold_seen != hold_trigger)
        begin
            hold_seen <= hold_trigger;
            hold_left <= LONG_HOLD;
            pulse_ready <= 1'b0;
        end
        else
            pulse_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic push_word(input logic [spg_pkg::OP_W-1:0] op,
                             input logic [spg_pkg::ANGLE_W-1:0] ang);
        cmd_queue.push_back('{op, ang});
        queued_words++;
    endtask

    task automatic push_ticks(input int n);
        for (int i = 0; i < n; i++)
            push_word(($urandom_range(15) == 0) ? OP_SPARE : spg_pkg::OP_TICK,
                      8'($urandom_range(255)));
    endtask

    task automatic wait_quiet();
        while (cmd_queue.size() != 0 || cmd_valid || pulse_expect.size() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic set_widths(input logic [spg_pkg::US_W-1:0] lo_us,
                              input logic [spg_pkg::US_W-1:0] hi_us);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= spg_pkg::CFG_MIN_PULSE;
        cfg_data <= lo_us;
        @(negedge clk);
        cfg_index <= spg_pkg::CFG_MAX_PULSE;
        cfg_data <= hi_us;
        @(negedge clk);
        cfg_we <= 1'b0;
        min_us = lo_us;
        max_us = hi_us;
    endtask

    function automatic logic [spg_pkg::ANGLE_W-1:0] pick_angle();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'(ANGLE_LIMIT);
            2: return 8'd255;
            3: return 8'($urandom_range(255, ANGLE_LIMIT + 1));
            default: return 8'($urandom_range(ANGLE_LIMIT));
        endcase
    endfunction

    // mostly set-angle followed by a tick run, some of them long enough to
    // cross into the low phase; the rest is loose noise
    task automatic random_words(input int n);
        int start;
        start = queued_words;
        while (queued_words - start < n)
        begin
            if ($urandom_range(99) < 75)
            begin
                push_word(spg_pkg::OP_SET_ANGLE, pick_angle());
                push_ticks(($urandom_range(3) == 0) ? $urandom_range(560, 230)
                                                    : $urandom_range(40, 1));
                if ($urandom_range(9) < 3)
                    push_word(spg_pkg::OP_STOP, 8'($urandom_range(255)));
            end
            else
                push_word(2'($urandom_range(3)), 8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        int spin;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // idle behavior, saturation, restart while running, stop
        push_word(spg_pkg::OP_TICK, 8'd255);
        push_word(OP_SPARE, 8'd0);
        push_word(spg_pkg::OP_STOP, 8'd255);
        push_word(spg_pkg::OP_TICK, 8'd0);
        push_word(spg_pkg::OP_SET_ANGLE, 8'd0);
        push_word(spg_pkg::OP_TICK, 8'd0);
        push_word(OP_SPARE, 8'd255);
        push_word(spg_pkg::OP_SET_ANGLE, 8'd180);
        push_word(spg_pkg::OP_TICK, 8'd0);
        push_word(spg_pkg::OP_SET_ANGLE, 8'd255);
        push_word(spg_pkg::OP_SET_ANGLE, 8'd181);
        push_word(spg_pkg::OP_SET_ANGLE, 8'd90);
        push_word(spg_pkg::OP_TICK, 8'd90);
        push_word(spg_pkg::OP_STOP, 8'd0);
        push_word(spg_pkg::OP_TICK, 8'd0);
        push_word(OP_SPARE, 8'd0);
        push_word(spg_pkg::OP_SET_ANGLE, 8'd1);
        push_word(spg_pkg::OP_STOP, 8'd170);
        wait_quiet();

        // max below min
        set_widths(12'd3000, 12'd1000);
        push_word(spg_pkg::OP_SET_ANGLE, 8'd45);
        push_word(spg_pkg::OP_TICK, 8'd0);
        wait_quiet();

        // zero-length high phase
        set_widths(12'd0, 12'd15);
        push_word(spg_pkg::OP_SET_ANGLE, 8'd100);
        push_word(spg_pkg::OP_TICK, 8'd0);
        push_word(spg_pkg::OP_TICK, 8'd0);
        wait_quiet();

        for (int sub = 0; sub < 9; sub++)
        begin
            case (sub / 3)
                0: begin send_idle_pct = 31; recv_idle_pct = 62; end
                1: begin send_idle_pct = 62; recv_idle_pct = 31; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (sub)
                0: set_widths(12'd16, 12'd31);
                1: set_widths(12'd0, 12'd15);
                2: set_widths(12'd4095, 12'd0);
                3: set_widths(12'd16, 12'd47);
                4: set_widths(12'($urandom_range(4095)), 12'($urandom_range(4095)));
                5: set_widths(12'd31, 12'd16);
                6: set_widths(12'd0, 12'd4095);
                7: set_widths(12'd16, 12'd47);
                default: set_widths(12'($urandom_range(64)), 12'($urandom_range(64)));
            endcase
            random_words(SUB_WORDS);
            if (sub == 6)
                hold_trigger++;
            wait_quiet();
        end

        while (cmd_queue.size() != 0 || cmd_valid)
            @(negedge clk);
        spin = 0;
        while (pulse_expect.size() != 0 && spin < 5000)
        begin
            @(negedge clk);
            spin++;
        end
        repeat (20) @(negedge clk);
        if (pulse_expect.size() != 0)
            note_failure($sformatf("%0d words never arrived", pulse_expect.size()));
        if (fail_count == 0)
            $display("servo_pulse_generator_top regression: pass");
        else
            $display("servo_pulse_generator_top regression: fail");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("servo_pulse_generator_top regression: fail");
        $finish;
    end

endmodule
